FILE: sv/colfx_pkg.sv
package colfx_pkg;

    // effect codes as written to the effect_mode register
    typedef enum logic [2:0] {
        MODE_PASS      = 3'd0,
        MODE_GRAY      = 3'd1,
        MODE_BLUE_TINT = 3'd2,
        MODE_RED_TINT  = 3'd3,
        MODE_SEPIA     = 3'd4,
        MODE_BRIGHTEN  = 3'd5
    } mode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTEN_PERCENT = 2'd1;

    localparam logic [2:0] EFFECT_MODE_RST      = 3'd0;
    localparam logic [8:0] BRIGHTEN_PERCENT_RST = 9'd200;

    // sepia matrix in thousandths
    localparam logic [9:0] SEP_RR = 10'd393;
    localparam logic [9:0] SEP_RG = 10'd769;
    localparam logic [9:0] SEP_RB = 10'd189;
    localparam logic [9:0] SEP_GR = 10'd349;
    localparam logic [9:0] SEP_GG = 10'd686;
    localparam logic [9:0] SEP_GB = 10'd168;
    localparam logic [9:0] SEP_BR = 10'd272;
    localparam logic [9:0] SEP_BG = 10'd534;
    localparam logic [9:0] SEP_BB = 10'd131;

    // sums at or above this give a quotient over 255
    localparam logic [18:0] SEP_SAT_LIMIT = 19'd256000;

    // reciprocal constants: floor(x/d) = (x * MULT) >> SHIFT over the used range
    localparam logic [18:0] DIV1000_MULT  = 19'd268436;
    localparam int          DIV1000_SHIFT = 28;
    localparam logic [17:0] DIV100_MULT   = 18'd167773;
    localparam int          DIV100_SHIFT  = 24;
    localparam logic [9:0]  DIV3_MULT     = 10'd683;
    localparam int          DIV3_SHIFT    = 11;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // after the product stage
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        mode_t       mode;
        logic [9:0]  sum3;
        logic [18:0] sep_r;
        logic [18:0] sep_g;
        logic [18:0] sep_b;
        logic [16:0] brt_r;
        logic [16:0] brt_g;
        logic [16:0] brt_b;
    } prod_t;

    // after the quotient stage
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        mode_t       mode;
        logic [7:0]  mean;
        logic [7:0]  sep_r;
        logic [7:0]  sep_g;
        logic [7:0]  sep_b;
        logic [10:0] add_r;
        logic [10:0] add_g;
        logic [10:0] add_b;
    } quot_t;

    // finished entry
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        mode_t      mode;
    } rgb_t;

endpackage

FILE: sv/colfx_chan_ifs.sv
interface colfx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface colfx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

FILE: sv/colfx_prod_stage.sv
module colfx_prod_stage
    import colfx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  mode_t      mode,
    input  logic [8:0] percent,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_t      out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    // sepia dot products, brighten products and the channel sum
    always_comb
    begin
        data_next.red   = red;
        data_next.green = green;
        data_next.blue  = blue;
        data_next.mode  = mode;
        data_next.sum3  = 10'(red) + 10'(green) + 10'(blue);
        data_next.sep_r = 19'(red) * 19'(SEP_RR) + 19'(green) * 19'(SEP_RG)
                        + 19'(blue) * 19'(SEP_RB);
        data_next.sep_g = 19'(red) * 19'(SEP_GR) + 19'(green) * 19'(SEP_GG)
                        + 19'(blue) * 19'(SEP_GB);
        data_next.sep_b = 19'(red) * 19'(SEP_BR) + 19'(green) * 19'(SEP_BG)
                        + 19'(blue) * 19'(SEP_BB);
        data_next.brt_r = 17'(red) * 17'(percent);
        data_next.brt_g = 17'(green) * 17'(percent);
        data_next.brt_b = 17'(blue) * 17'(percent);
    end

    assign in_ready = ~valid_reg | out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/colfx_quot_stage.sv
module colfx_quot_stage
    import colfx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_data
);

    logic  valid_reg;
    quot_t data_reg;
    quot_t data_next;

    logic [18:0] mean_prod;
    logic [36:0] sep_r_prod;
    logic [36:0] sep_g_prod;
    logic [36:0] sep_b_prod;
    logic [34:0] add_r_prod;
    logic [34:0] add_g_prod;
    logic [34:0] add_b_prod;

    // reciprocal multiplies for /3, /1000 and /100
    always_comb
    begin
        mean_prod  = 19'(in_data.sum3) * 19'(DIV3_MULT);
        sep_r_prod = 37'(in_data.sep_r[17:0]) * 37'(DIV1000_MULT);
        sep_g_prod = 37'(in_data.sep_g[17:0]) * 37'(DIV1000_MULT);
        sep_b_prod = 37'(in_data.sep_b[17:0]) * 37'(DIV1000_MULT);
        add_r_prod = 35'(in_data.brt_r) * 35'(DIV100_MULT);
        add_g_prod = 35'(in_data.brt_g) * 35'(DIV100_MULT);
        add_b_prod = 35'(in_data.brt_b) * 35'(DIV100_MULT);
    end

    // quotients, sepia saturated before the divide result is used
    always_comb
    begin
        data_next.red   = in_data.red;
        data_next.green = in_data.green;
        data_next.blue  = in_data.blue;
        data_next.mode  = in_data.mode;
        data_next.mean  = mean_prod[DIV3_SHIFT +: 8];
        data_next.sep_r = (in_data.sep_r >= SEP_SAT_LIMIT) ? CHAN_MAX
                        : sep_r_prod[DIV1000_SHIFT +: 8];
        data_next.sep_g = (in_data.sep_g >= SEP_SAT_LIMIT) ? CHAN_MAX
                        : sep_g_prod[DIV1000_SHIFT +: 8];
        data_next.sep_b = (in_data.sep_b >= SEP_SAT_LIMIT) ? CHAN_MAX
                        : sep_b_prod[DIV1000_SHIFT +: 8];
        data_next.add_r = add_r_prod[DIV100_SHIFT +: 11];
        data_next.add_g = add_g_prod[DIV100_SHIFT +: 11];
        data_next.add_b = add_b_prod[DIV100_SHIFT +: 11];
    end

    assign in_ready = ~valid_reg | out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/colfx_mix_stage.sv
module colfx_mix_stage
    import colfx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  quot_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rgb_t  out_data
);

    logic valid_reg;
    rgb_t data_reg;
    rgb_t data_next;

    logic [11:0] brt_r_sum;
    logic [11:0] brt_g_sum;
    logic [11:0] brt_b_sum;
    logic [7:0]  brt_r;
    logic [7:0]  brt_g;
    logic [7:0]  brt_b;

    // brighten: channel plus its share, clipped at full scale
    always_comb
    begin
        brt_r_sum = 12'(in_data.red) + 12'(in_data.add_r);
        brt_g_sum = 12'(in_data.green) + 12'(in_data.add_g);
        brt_b_sum = 12'(in_data.blue) + 12'(in_data.add_b);
        brt_r = (brt_r_sum > 12'(CHAN_MAX)) ? CHAN_MAX : brt_r_sum[7:0];
        brt_g = (brt_g_sum > 12'(CHAN_MAX)) ? CHAN_MAX : brt_g_sum[7:0];
        brt_b = (brt_b_sum > 12'(CHAN_MAX)) ? CHAN_MAX : brt_b_sum[7:0];
    end

    // effect select
    always_comb
    begin
        data_next.red   = in_data.red;
        data_next.green = in_data.green;
        data_next.blue  = in_data.blue;
        data_next.mode  = in_data.mode;
        unique case (in_data.mode)
            MODE_GRAY:
            begin
                data_next.red   = in_data.mean;
                data_next.green = in_data.mean;
                data_next.blue  = in_data.mean;
            end
            MODE_BLUE_TINT:
            begin
                data_next.red   = in_data.mean;
                data_next.green = in_data.mean;
            end
            MODE_RED_TINT:
            begin
                data_next.green = in_data.mean;
                data_next.blue  = in_data.mean;
            end
            MODE_SEPIA:
            begin
                data_next.red   = in_data.sep_r;
                data_next.green = in_data.sep_g;
                data_next.blue  = in_data.sep_b;
            end
            MODE_BRIGHTEN:
            begin
                data_next.red   = brt_r;
                data_next.green = brt_g;
                data_next.blue  = brt_b;
            end
            default:
            begin
                data_next.red = in_data.red;
            end
        endcase
    end

    assign in_ready = ~valid_reg | out_ready;

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/palette_colour_effect_top.sv
// channel   dir  transfer when        payload
// pix_in    in   valid && ready       red_in, green_in, blue_in (8 bit each)
// pix_out   out  valid && ready       red_out, green_out, blue_out (8 bit each)
// cfg       in   cfg_we               cfg_index (2 bit), cfg_data (9 bit)
//
// one entry per cycle sustained while pix_out.ready is high; each entry is registered
// in turn by the product stage, reciprocal-multiply stage and select/output register
// rst_n is asynchronous; it empties the pipeline and loads the register defaults
// each stage holds while the stage after it is full and stalled, so a stalled
// output backs up stage by stage and pix_in.ready drops once all three are full
module palette_colour_effect_top
    import colfx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    colfx_in_if.sink              pix_in,
    colfx_out_if.source           pix_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mode_t      effect_mode_reg;
    logic [8:0] brighten_percent_reg;

    logic  prod_valid;
    logic  prod_ready;
    prod_t prod_data;
    logic  quot_valid;
    logic  quot_ready;
    quot_t quot_data;
    rgb_t  mix_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg      <= mode_t'(EFFECT_MODE_RST);
            brighten_percent_reg <= BRIGHTEN_PERCENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:
                begin
                    effect_mode_reg <= mode_t'(cfg_data[2:0]);
                end
                REG_BRIGHTEN_PERCENT:
                begin
                    brighten_percent_reg <= cfg_data[8:0];
                end
                default:
                begin
                    effect_mode_reg <= effect_mode_reg;
                end
            endcase
        end
    end

    colfx_prod_stage u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .red       (pix_in.red_in),
        .green     (pix_in.green_in),
        .blue      (pix_in.blue_in),
        .mode      (effect_mode_reg),
        .percent   (brighten_percent_reg),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    colfx_quot_stage u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_data  (quot_data)
    );

    colfx_mix_stage u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quot_valid),
        .in_ready  (quot_ready),
        .in_data   (quot_data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (mix_data)
    );

    assign pix_out.red_out   = mix_data.red;
    assign pix_out.green_out = mix_data.green;
    assign pix_out.blue_out  = mix_data.blue;

    // a full, stalled pipeline must refuse new entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && quot_valid && pix_out.valid && !pix_out.ready) |-> !pix_in.ready)
        else $error("input accepted while pipeline full and stalled");

    // a new result only appears from an occupied quotient stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_out.valid) |-> $past(quot_valid))
        else $error("output valid without an entry behind it");

    // grayscale results are neutral
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && mix_data.mode == MODE_GRAY) |->
        (pix_out.red_out == pix_out.green_out && pix_out.green_out == pix_out.blue_out))
        else $error("grayscale result not neutral");

    // sepia rows are ordered, so red >= green >= blue
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && mix_data.mode == MODE_SEPIA) |->
        (pix_out.red_out >= pix_out.green_out && pix_out.green_out >= pix_out.blue_out))
        else $error("sepia channel order broken");

endmodule
